@@ hw/rtl/tis_pkg.sv @@
// Shared constants, payload types and pipeline structs for the triangle isoline block.
`timescale 1ns / 1ps
`default_nettype none
package tis_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_LEVELS = 16;
	localparam int RESULT_CAP = 16;
	localparam int LEVEL_CAP  = (MAX_LEVELS < RESULT_CAP) ? MAX_LEVELS : RESULT_CAP;

	localparam int VAL_W     = 32;
	localparam int CNT_W     = 5;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W     = VAL_W + 1;
	localparam int T_W       = FRAC_BITS + 1;
	localparam int PROD_W    = DIV_W + T_W;
	localparam int RND_W     = PROD_W - FRAC_BITS;
	localparam int SUM_W     = RND_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_ISO_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd2;

	localparam logic [CNT_W-1:0] LEVEL_CAP_C = CNT_W'(LEVEL_CAP);

	// One triangle
	typedef struct packed {
		logic signed [VAL_W-1:0] value_a;
		logic signed [VAL_W-1:0] value_b;
		logic signed [VAL_W-1:0] value_c;
		logic signed [VAL_W-1:0] corner_a_x;
		logic signed [VAL_W-1:0] corner_a_y;
		logic signed [VAL_W-1:0] corner_a_z;
		logic signed [VAL_W-1:0] corner_b_x;
		logic signed [VAL_W-1:0] corner_b_y;
		logic signed [VAL_W-1:0] corner_b_z;
		logic signed [VAL_W-1:0] corner_c_x;
		logic signed [VAL_W-1:0] corner_c_y;
		logic signed [VAL_W-1:0] corner_c_z;
	} face_t;

	// One segment
	typedef struct packed {
		logic [IDX_W-1:0]        level_index;
		logic signed [VAL_W-1:0] start_x;
		logic signed [VAL_W-1:0] start_y;
		logic signed [VAL_W-1:0] start_z;
		logic signed [VAL_W-1:0] end_x;
		logic signed [VAL_W-1:0] end_y;
		logic signed [VAL_W-1:0] end_z;
		logic                    last_segment;
	} seg_t;

	// One level of one triangle, as issued into the pipeline
	typedef struct packed {
		face_t                   face;
		logic signed [VAL_W-1:0] level;
		logic [IDX_W-1:0]        idx;
		logic                    tail;
	} issue_t;

	// Control that rides along with every pipeline slot
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             tail;
		logic             hit;
	} ctl_t;

	// One crossed edge: divide operands and interpolation operands
	typedef struct packed {
		logic [DIV_W-1:0]            num;
		logic [DIV_W-1:0]            den;
		logic [2:0][VAL_W-1:0]       pa;
		logic [2:0][DIV_W-1:0]       dpm;
		logic [2:0]                  dneg;
	} lane_t;

	// Finished slot at the pipeline tail
	typedef struct packed {
		seg_t seg;
		logic tail;
		logic hit;
	} entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/tis_level_gen.sv @@
// Configuration registers, level step divider and per-triangle level sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tis_level_gen (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tis_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [tis_pkg::VAL_W-1:0]      cfg_data,
	input  wire logic                           face_valid,
	output logic                                face_ready,
	input  wire tis_pkg::face_t                 face,
	input  wire logic                           adv,
	output logic                                iss_valid,
	output tis_pkg::issue_t                     iss
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_RUN  = 3'b100
	} div_state_t;

	logic [tis_pkg::CNT_W-1:0]        iso_q;
	logic signed [tis_pkg::VAL_W-1:0] min_q, max_q;

	div_state_t                       st_q;
	logic [tis_pkg::VAL_W-1:0]        dvd_q;
	logic [tis_pkg::CNT_W-1:0]        dvs_q, rem_q, cnt_q;

	logic                             busy_q;
	logic [tis_pkg::IDX_W-1:0]        idx_q;
	logic signed [tis_pkg::VAL_W-1:0] lvl_q;
	logic [tis_pkg::CNT_W-1:0]        racc_q;
	tis_pkg::face_t                   face_q;

	logic [tis_pkg::CNT_W-1:0]        n_eff, dvs;
	logic                             enabled;
	logic [tis_pkg::IDX_W-1:0]        last_idx;
	logic [tis_pkg::CNT_W:0]          rem_t, rsum;
	logic                             rem_ge, wrap;

	// Effective level count and step divisor
	assign n_eff    = (iso_q > tis_pkg::LEVEL_CAP_C) ? tis_pkg::LEVEL_CAP_C : iso_q;
	assign dvs      = n_eff + tis_pkg::CNT_W'(1);
	assign enabled  = (n_eff != '0) && (min_q < max_q);
	assign last_idx = tis_pkg::IDX_W'(n_eff - tis_pkg::CNT_W'(1));

	// Restoring divide step: (max - min) / (n + 1), one quotient bit per cycle
	assign rem_t  = {rem_q, dvd_q[tis_pkg::VAL_W-1]};
	assign rem_ge = rem_t >= {1'b0, dvs_q};

	// Level accumulator step: remainder carries into the quotient
	assign rsum = {1'b0, racc_q} + {1'b0, rem_q};
	assign wrap = rsum >= {1'b0, dvs};

	assign face_ready = !busy_q && (st_q == ST_IDLE);
	assign iss_valid  = busy_q;
	always_comb begin
		iss.face  = face_q;
		iss.level = lvl_q;
		iss.idx   = idx_q;
		iss.tail  = (idx_q == last_idx);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
			min_q <= '0;
			max_q <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tis_pkg::REG_ISO_COUNT: iso_q <= cfg_data[tis_pkg::CNT_W-1:0];
				tis_pkg::REG_RANGE_MIN: min_q <= cfg_data;
				tis_pkg::REG_RANGE_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step divider control; any write restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else if (cfg_we) begin
			st_q <= ST_LOAD;
		end else begin
			unique case (st_q)
				ST_IDLE: ;
				ST_LOAD: begin
					st_q  <= ST_RUN;
					cnt_q <= '0;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + tis_pkg::CNT_W'(1);
					if (cnt_q == tis_pkg::CNT_W'(tis_pkg::VAL_W - 1))
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Step divider datapath: dvd_q ends as the quotient, rem_q as the remainder
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD) begin
			dvd_q <= tis_pkg::VAL_W'(max_q - min_q);
			dvs_q <= dvs;
			rem_q <= '0;
		end else if (st_q == ST_RUN) begin
			dvd_q <= {dvd_q[tis_pkg::VAL_W-2:0], rem_ge};
			rem_q <= rem_ge ? tis_pkg::CNT_W'(rem_t - {1'b0, dvs_q})
			                : tis_pkg::CNT_W'(rem_t);
		end
	end

	// Level sequencer: one level issued per advancing cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (face_valid && face_ready) begin
			busy_q <= enabled;
		end else if (busy_q && adv && iss.tail) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (face_valid && face_ready) begin
			face_q <= face;
			idx_q  <= '0;
			lvl_q  <= min_q + signed'(dvd_q);
			racc_q <= rem_q;
		end else if (busy_q && adv) begin
			idx_q  <= idx_q + tis_pkg::IDX_W'(1);
			lvl_q  <= lvl_q + signed'(dvd_q) + signed'({31'd0, wrap});
			racc_q <= wrap ? tis_pkg::CNT_W'(rsum - {1'b0, dvs}) : tis_pkg::CNT_W'(rsum);
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/tis_cross_setup.sv @@
// Corner classification and crossed-edge selection for one level.
`timescale 1ns / 1ps
`default_nettype none
module tis_cross_setup (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                iss_valid,
	input  wire tis_pkg::issue_t     iss,
	output logic                     v_s1,
	output tis_pkg::ctl_t            ctl_s1,
	output tis_pkg::lane_t [1:0]     lane_s1
);

	logic signed [tis_pkg::VAL_W-1:0]    s [3];
	logic [2:0][tis_pkg::VAL_W-1:0]      p [3];
	logic signed [tis_pkg::VAL_W:0]      d [3];
	logic [2:0]                          above;
	logic                                x_ab, x_bc, x_ca;
	tis_pkg::lane_t                      l_ab, l_bc, l_ca;
	tis_pkg::lane_t [1:0]                lane_n;
	tis_pkg::ctl_t                       ctl_n;

	function automatic logic [tis_pkg::DIV_W-1:0] mag(input logic signed [tis_pkg::VAL_W:0] v);
		logic signed [tis_pkg::VAL_W:0] n;
		n = -v;
		return v[tis_pkg::VAL_W] ? n : v;
	endfunction

	// Operands for the edge from corner k to corner j
	function automatic tis_pkg::lane_t mk_lane(
		input logic signed [tis_pkg::VAL_W-1:0] sk, input logic signed [tis_pkg::VAL_W-1:0] sj,
		input logic signed [tis_pkg::VAL_W:0] dk,
		input logic [2:0][tis_pkg::VAL_W-1:0] pk, input logic [2:0][tis_pkg::VAL_W-1:0] pj);
		tis_pkg::lane_t                 l;
		logic signed [tis_pkg::VAL_W:0] dp;
		l.num = mag(dk);
		l.den = mag({sk[tis_pkg::VAL_W-1], sk} - {sj[tis_pkg::VAL_W-1], sj});
		for (int c = 0; c < 3; c++) begin
			dp = {pj[c][tis_pkg::VAL_W-1], pj[c]} - {pk[c][tis_pkg::VAL_W-1], pk[c]};
			l.pa[c]   = pk[c];
			l.dpm[c]  = mag(dp);
			l.dneg[c] = dp[tis_pkg::VAL_W];
		end
		return l;
	endfunction

	always_comb begin
		s[0] = iss.face.value_a;
		s[1] = iss.face.value_b;
		s[2] = iss.face.value_c;
		p[0] = {iss.face.corner_a_z, iss.face.corner_a_y, iss.face.corner_a_x};
		p[1] = {iss.face.corner_b_z, iss.face.corner_b_y, iss.face.corner_b_x};
		p[2] = {iss.face.corner_c_z, iss.face.corner_c_y, iss.face.corner_c_x};
		// Signed distance to the level; a corner on the level is not above
		for (int k = 0; k < 3; k++) begin
			d[k]     = {s[k][tis_pkg::VAL_W-1], s[k]} - {iss.level[tis_pkg::VAL_W-1], iss.level};
			above[k] = !d[k][tis_pkg::VAL_W] && (d[k] != '0);
		end
	end

	assign x_ab = above[0] ^ above[1];
	assign x_bc = above[1] ^ above[2];
	assign x_ca = above[2] ^ above[0];

	assign l_ab = mk_lane(s[0], s[1], d[0], p[0], p[1]);
	assign l_bc = mk_lane(s[1], s[2], d[1], p[1], p[2]);
	assign l_ca = mk_lane(s[2], s[0], d[2], p[2], p[0]);

	// Crossings come in pairs; keep them in edge order a-b, b-c, c-a
	always_comb begin
		lane_n[0]  = x_ab ? l_ab : l_bc;
		lane_n[1]  = (x_ab && x_bc) ? l_bc : l_ca;
		ctl_n.idx  = iss.idx;
		ctl_n.tail = iss.tail;
		ctl_n.hit  = x_ab || x_bc || x_ca;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= iss_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= ctl_n;
			lane_s1 <= lane_n;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/tis_div_pipe.sv @@
// Pipelined restoring divider: t = |d_a| * 2^FRAC_BITS / |d_a - d_b|, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tis_div_pipe (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire logic                               v_in,
	input  wire tis_pkg::ctl_t                      ctl_in,
	input  wire tis_pkg::lane_t [1:0]               lane_in,
	output logic                                    v_out,
	output tis_pkg::ctl_t                           ctl_out,
	output tis_pkg::lane_t [1:0]                    lane_out,
	output logic [1:0][tis_pkg::T_W-1:0]            t_out
);

	localparam int NS = tis_pkg::T_W;

	logic                                    v_s   [NS];
	tis_pkg::ctl_t                           ctl_s [NS];
	tis_pkg::lane_t [1:0]                    lane_s[NS];
	logic [1:0][tis_pkg::DIV_W-1:0]          rem_s [NS];
	logic [1:0][tis_pkg::T_W-1:0]            quo_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic                             v_p;
		tis_pkg::ctl_t                    ctl_p;
		tis_pkg::lane_t [1:0]             lane_p;
		logic [1:0][tis_pkg::DIV_W:0]     r_in;
		logic [1:0][tis_pkg::T_W-1:0]     quo_p;
		logic [1:0]                       ge;
		logic [1:0][tis_pkg::DIV_W-1:0]   rem_n;
		logic [1:0][tis_pkg::T_W-1:0]     quo_n;

		// Stage input: the first stage compares the numerator unshifted
		if (g == 0) begin : g_first
			always_comb begin
				v_p    = v_in;
				ctl_p  = ctl_in;
				lane_p = lane_in;
				for (int l = 0; l < 2; l++) begin
					r_in[l]  = {1'b0, lane_in[l].num};
					quo_p[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				v_p    = v_s[g-1];
				ctl_p  = ctl_s[g-1];
				lane_p = lane_s[g-1];
				for (int l = 0; l < 2; l++) begin
					r_in[l]  = {rem_s[g-1][l], 1'b0};
					quo_p[l] = quo_s[g-1][l];
				end
			end
		end

		// Compare and subtract
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				ge[l]    = r_in[l] >= {1'b0, lane_p[l].den};
				rem_n[l] = ge[l] ? tis_pkg::DIV_W'(r_in[l] - {1'b0, lane_p[l].den})
				                 : tis_pkg::DIV_W'(r_in[l]);
				quo_n[l] = {quo_p[l][tis_pkg::T_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[g] <= 1'b0;
			else if (adv)
				v_s[g] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[g]  <= ctl_p;
				lane_s[g] <= lane_p;
				rem_s[g]  <= rem_n;
				quo_s[g]  <= quo_n;
			end
		end
	end

	assign v_out    = v_s[NS-1];
	assign ctl_out  = ctl_s[NS-1];
	assign lane_out = lane_s[NS-1];
	assign t_out    = quo_s[NS-1];

endmodule
`default_nettype wire

@@ hw/rtl/tis_interp.sv @@
// Edge interpolation: scale the coordinate step by t, round, add and saturate.
`timescale 1ns / 1ps
`default_nettype none
module tis_interp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             adv,
	input  wire logic                             v_in,
	input  wire tis_pkg::ctl_t                    ctl_in,
	input  wire tis_pkg::lane_t [1:0]             lane_in,
	input  wire logic [1:0][tis_pkg::T_W-1:0]     t_in,
	output logic                                  v_s2,
	output tis_pkg::entry_t                       ent_s2
);

	logic                                         v_s1;
	tis_pkg::ctl_t                                ctl_s1;
	logic [1:0][2:0][tis_pkg::PROD_W-1:0]         prod_s1;
	logic [1:0][2:0][tis_pkg::VAL_W-1:0]          pa_s1;
	logic [1:0][2:0]                              neg_s1;
	logic [1:0][2:0][tis_pkg::VAL_W-1:0]          pt;
	tis_pkg::entry_t                              ent_n;

	// Round half away from zero, apply sign, add to the start corner, saturate
	function automatic logic [tis_pkg::VAL_W-1:0] finish(
		input logic [tis_pkg::VAL_W-1:0] pa, input logic [tis_pkg::PROD_W-1:0] prod,
		input logic neg);
		logic [tis_pkg::PROD_W-1:0]      rsum;
		logic signed [tis_pkg::SUM_W-1:0] a, dl, s;
		rsum = prod + tis_pkg::PROD_W'(1 << (tis_pkg::FRAC_BITS - 1));
		a    = {{(tis_pkg::SUM_W - tis_pkg::VAL_W){pa[tis_pkg::VAL_W-1]}}, pa};
		dl   = {2'b00, rsum[tis_pkg::PROD_W-1:tis_pkg::FRAC_BITS]};
		s    = neg ? a - dl : a + dl;
		if (s > tis_pkg::SUM_W'(32'sh7FFF_FFFF))
			return 32'h7FFF_FFFF;
		else if (s < -(tis_pkg::SUM_W'(33'sh0_8000_0000)))
			return 32'h8000_0000;
		else
			return s[tis_pkg::VAL_W-1:0];
	endfunction

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= v_in;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			for (int l = 0; l < 2; l++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[l][c] <= tis_pkg::PROD_W'(lane_in[l].dpm[c]) *
					                 tis_pkg::PROD_W'(t_in[l]);
					pa_s1[l][c]   <= lane_in[l].pa[c];
					neg_s1[l][c]  <= lane_in[l].dneg[c];
				end
			end
		end
	end

	// Round and add stage
	always_comb begin
		for (int l = 0; l < 2; l++)
			for (int c = 0; c < 3; c++)
				pt[l][c] = finish(pa_s1[l][c], prod_s1[l][c], neg_s1[l][c]);
		ent_n.seg.level_index  = ctl_s1.idx;
		ent_n.seg.start_x      = pt[0][0];
		ent_n.seg.start_y      = pt[0][1];
		ent_n.seg.start_z      = pt[0][2];
		ent_n.seg.end_x        = pt[1][0];
		ent_n.seg.end_y        = pt[1][1];
		ent_n.seg.end_z        = pt[1][2];
		ent_n.seg.last_segment = 1'b0;
		ent_n.tail             = ctl_s1.tail;
		ent_n.hit              = ctl_s1.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			ent_s2 <= ent_n;
	end

endmodule
`default_nettype wire

@@ hw/rtl/tis_out_buf.sv @@
// Output stage: holds back one segment until it is known whether it is the last one.
`timescale 1ns / 1ps
`default_nettype none
module tis_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              e_valid,
	input  wire tis_pkg::entry_t   ent,
	output logic                   adv,
	output logic                   seg_valid,
	input  wire logic              seg_ready,
	output tis_pkg::seg_t          seg
);

	logic          ov_q, pv_q, pfin_q;
	tis_pkg::seg_t out_q, pend_q, pend_out;
	logic          e_hit, e_tail, push, slot_free;

	assign e_hit     = e_valid && ent.hit;
	assign e_tail    = e_valid && ent.tail;
	assign slot_free = !ov_q || seg_ready;
	// The held segment leaves once a later one or its triangle's end shows up
	assign push      = pv_q && (pfin_q || e_hit);
	assign adv       = !push || slot_free;

	assign seg_valid = ov_q;
	assign seg       = out_q;

	// Held segment with its last mark
	always_comb begin
		pend_out              = pend_q;
		pend_out.last_segment = pfin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			pv_q   <= 1'b0;
			pfin_q <= 1'b0;
		end else if (adv) begin
			if (push)
				ov_q <= 1'b1;
			else if (seg_ready)
				ov_q <= 1'b0;

			if (e_hit) begin
				pv_q   <= 1'b1;
				pfin_q <= e_tail;
			end else if (push) begin
				pv_q   <= 1'b0;
				pfin_q <= 1'b0;
			end else if (e_tail && pv_q) begin
				pfin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (push)
				out_q <= pend_out;
			if (e_hit)
				pend_q <= ent.seg;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/triangle_isoline_segments.sv @@
// Top level: isoline segments through one triangle for a set of evenly spaced levels.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  face     | face_valid / face_ready   | face  (tis_pkg::face_t)
//  seg      | seg_valid / seg_ready     | seg   (tis_pkg::seg_t)
//  cfg      | cfg_we, write-only        | cfg_idx, cfg_data
//
// The level sequencer holds a triangle until its n levels (n = levels in use, at most 16)
// have entered the pipeline, one per cycle unless seg stalls; the next triangle is taken
// in the cycle after the last one. A disabled configuration issues no level for a triangle.
// Each config write restarts the level step divider; face_ready stays low meanwhile.
// Pipeline: issue, edge setup, 17 divide stages, multiply, round, output; a stall on seg
// freezes every stage together.
`timescale 1ns / 1ps
`default_nettype none
module triangle_isoline_segments (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tis_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [tis_pkg::VAL_W-1:0]       cfg_data,
	input  wire logic                            face_valid,
	output logic                                 face_ready,
	input  wire tis_pkg::face_t                  face,
	output logic                                 seg_valid,
	input  wire logic                            seg_ready,
	output tis_pkg::seg_t                        seg
);

	logic                                  adv;
	logic                                  iss_valid;
	tis_pkg::issue_t                       iss;
	logic                                  v_x;
	tis_pkg::ctl_t                         ctl_x;
	tis_pkg::lane_t [1:0]                  lane_x;
	logic                                  v_d;
	tis_pkg::ctl_t                         ctl_d;
	tis_pkg::lane_t [1:0]                  lane_d;
	logic [1:0][tis_pkg::T_W-1:0]          t_d;
	logic                                  v_e;
	tis_pkg::entry_t                       ent_e;

	tis_level_gen u_level (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.face_valid, .face_ready, .face,
		.adv, .iss_valid, .iss
	);

	tis_cross_setup u_cross (
		.clk, .arst_n, .adv, .iss_valid, .iss,
		.v_s1(v_x), .ctl_s1(ctl_x), .lane_s1(lane_x)
	);

	tis_div_pipe u_div (
		.clk, .arst_n, .adv,
		.v_in(v_x), .ctl_in(ctl_x), .lane_in(lane_x),
		.v_out(v_d), .ctl_out(ctl_d), .lane_out(lane_d), .t_out(t_d)
	);

	tis_interp u_interp (
		.clk, .arst_n, .adv,
		.v_in(v_d), .ctl_in(ctl_d), .lane_in(lane_d), .t_in(t_d),
		.v_s2(v_e), .ent_s2(ent_e)
	);

	tis_out_buf u_out (
		.clk, .arst_n, .e_valid(v_e), .ent(ent_e),
		.adv, .seg_valid, .seg_ready, .seg
	);

endmodule
`default_nettype wire
